// File: src/polyphase_pulse_shaper_defines.svh
// ----------------------------------------------------------------------------
// Polyphase pulse shaper assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_PULSE_SHAPER_DEFINES_SVH
`define POLYPHASE_PULSE_SHAPER_DEFINES_SVH

// Same-cycle implication.
`define PPS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pps assertion failed");

// Next-cycle implication.
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pps assertion failed");

`endif

// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// Polyphase pulse shaper package
// Codes, defaults, field widths and the control structs shared by the modules.
// Memory depths are expected to be powers of two.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int DEF_MAX_PHASES = 32;
	localparam int DEF_MAX_TAPS   = 32;
	localparam int DEF_COEF_DEPTH = 1024;
	localparam int DEF_MAP_DEPTH  = 256;

	localparam int QSHIFT = 15;

	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		CMD_SYMBOL  = 2'd0,
		CMD_COEF    = 2'd1,
		CMD_MAP     = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_COUNT = 3'd0,
		REG_PHASE_STEP  = 3'd1,
		REG_STEP_TRIM   = 3'd2,
		REG_MAP_ENABLE  = 3'd3,
		REG_OUT_GAIN    = 3'd4,
		REG_TAP_COUNT   = 3'd5
	} reg_idx_t;

	localparam logic [5:0]  RST_PHASE_COUNT = 6'd10;
	localparam logic [4:0]  RST_PHASE_STEP  = 5'd3;
	localparam logic [5:0]  RST_STEP_TRIM   = 6'd0;
	localparam logic        RST_MAP_ENABLE  = 1'b1;
	localparam logic [15:0] RST_OUT_GAIN    = 16'h7fff;
	localparam logic [5:0]  RST_TAP_COUNT   = 6'd12;

	typedef struct packed {
		logic sym_ld;
		logic coef_we;
		logic map_we;
		logic hist_clr;
		logic push;
		logic acc_clr;
		logic mac_issue;
		logic prod_ld;
	} pps_cmd_t;

	typedef struct packed {
		logic mac_busy;
	} pps_sts_t;

endpackage

// File: src/pps_dp.sv
// ----------------------------------------------------------------------------
// Polyphase pulse shaper datapath
// Coefficient, map and history stores, the two rail MAC pipelines and gain.
// ----------------------------------------------------------------------------
module pps_dp
	import pps_pkg::*;
#(
	parameter int MAX_TAPS   = DEF_MAX_TAPS,
	parameter int COEF_DEPTH = DEF_COEF_DEPTH,
	parameter int MAP_DEPTH  = DEF_MAP_DEPTH,
	localparam int PW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
	localparam int CAW = $clog2(COEF_DEPTH),
	localparam int MW  = $clog2(MAP_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pps_cmd_t              cmd,
	output pps_sts_t              sts,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [IN_USER_W-1:0]  in_user,
	input  logic [PW-1:0]         push_pos,
	input  logic [PW-1:0]         mac_pos,
	input  logic [CAW-1:0]        mac_caddr,
	input  logic                  map_en,
	input  logic signed [15:0]    gain,
	output logic [OUT_DATA_W-1:0] sample
);

	logic [7:0]         sym_idx_q;
	logic signed [15:0] sym_i_q, sym_q_q;
	logic signed [15:0] coef_i_mem [COEF_DEPTH];
	logic signed [15:0] coef_q_mem [COEF_DEPTH];
	logic signed [15:0] map_i_mem [MAP_DEPTH];
	logic signed [15:0] map_q_mem [MAP_DEPTH];
	logic signed [15:0] hist_i_q [MAX_TAPS];
	logic signed [15:0] hist_q_q [MAX_TAPS];
	logic [MAX_TAPS-1:0] hist_vld_q;
	logic signed [15:0] map_i_rd_q, map_q_rd_q;
	logic signed [15:0] coef_i_s1, coef_q_s1, hist_i_s1, hist_q_s1;
	logic signed [31:0] prod_i_s2, prod_q_s2;
	logic               v_s1, v_s2;
	logic [31:0]        acc_i_q, acc_q_q;
	logic signed [31:0] gain_prod_q;
	logic signed [15:0] ld_val, push_i, push_q, diff;
	logic [9:0]         ld_addr;
	logic               ld_rail;

	assign ld_addr = in_data[49:40];
	assign ld_val  = in_data[65:50];
	assign ld_rail = in_user[2];
	assign push_i  = map_en ? map_i_rd_q : sym_i_q;
	assign push_q  = map_en ? map_q_rd_q : sym_q_q;
	assign diff    = acc_i_q[30:15] - acc_q_q[30:15];

	always_ff @(posedge clk) begin
		if (cmd.sym_ld) begin
			sym_idx_q <= in_data[7:0];
			sym_i_q   <= in_data[23:8];
			sym_q_q   <= in_data[39:24];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.coef_we && !ld_rail) begin
			coef_i_mem[CAW'(ld_addr)] <= ld_val;
		end
		if (cmd.coef_we && ld_rail) begin
			coef_q_mem[CAW'(ld_addr)] <= ld_val;
		end
		coef_i_s1 <= coef_i_mem[mac_caddr];
		coef_q_s1 <= coef_q_mem[mac_caddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.map_we && !ld_rail) begin
			map_i_mem[MW'(ld_addr[7:0])] <= ld_val;
		end
		if (cmd.map_we && ld_rail) begin
			map_q_mem[MW'(ld_addr[7:0])] <= ld_val;
		end
		map_i_rd_q <= map_i_mem[MW'(sym_idx_q)];
		map_q_rd_q <= map_q_mem[MW'(sym_idx_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hist_i_q[push_pos] <= push_i;
			hist_q_q[push_pos] <= push_q;
		end
		hist_i_s1 <= hist_vld_q[mac_pos] ? hist_i_q[mac_pos] : 16'sd0;
		hist_q_s1 <= hist_vld_q[mac_pos] ? hist_q_q[mac_pos] : 16'sd0;
		prod_i_s2 <= hist_i_s1 * coef_i_s1;
		prod_q_s2 <= hist_q_s1 * coef_q_s1;
		if (cmd.prod_ld) begin
			gain_prod_q <= diff * gain;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			acc_i_q    <= '0;
			acc_q_q    <= '0;
		end else begin
			if (cmd.hist_clr) begin
				hist_vld_q <= '0;
			end else if (cmd.push) begin
				hist_vld_q[push_pos] <= 1'b1;
			end
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
			if (cmd.acc_clr) begin
				acc_i_q <= '0;
				acc_q_q <= '0;
			end else if (v_s2) begin
				acc_i_q <= acc_i_q + 32'(prod_i_s2);
				acc_q_q <= acc_q_q + 32'(prod_q_s2);
			end
		end
	end

	assign sts.mac_busy = v_s1 | v_s2;
	assign sample       = gain_prod_q[30:15];

endmodule

// File: src/pps_ctrl.sv
// ----------------------------------------------------------------------------
// Polyphase pulse shaper controller
// Configuration registers, phase accumulator, history pointer and sequencer.
// ----------------------------------------------------------------------------
module pps_ctrl
	import pps_pkg::*;
#(
	parameter int MAX_PHASES = DEF_MAX_PHASES,
	parameter int MAX_TAPS   = DEF_MAX_TAPS,
	parameter int COEF_DEPTH = DEF_COEF_DEPTH,
	localparam int PW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
	localparam int TW  = $clog2(MAX_TAPS + 1) + 1,
	localparam int CAW = $clog2(COEF_DEPTH),
	localparam int NW  = $clog2(MAX_PHASES + 2)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	output logic                  in_rdy,
	input  logic [1:0]            in_cmd,
	output logic                  out_vld,
	input  logic                  out_rdy,
	output logic                  out_last,
	input  logic                  cfg_vld,
	output logic                  cfg_rdy,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_dat,
	output pps_cmd_t              cmd,
	input  pps_sts_t              sts,
	output logic [PW-1:0]         push_pos,
	output logic [PW-1:0]         mac_pos,
	output logic [CAW-1:0]        mac_caddr,
	output logic                  map_en,
	output logic signed [15:0]    gain
);

	`include "polyphase_pulse_shaper_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_PUSH, ST_MAC, ST_DRAIN, ST_DIFF, ST_SEND
	} state_t;

	localparam int CAP = MAX_PHASES + 1;

	state_t             state_q;
	logic [5:0]         phase_count_q, tap_count_q;
	logic [4:0]         phase_step_q;
	logic signed [5:0]  step_trim_q;
	logic               map_en_q;
	logic signed [15:0] gain_q;
	logic [6:0]         phase_acc_q;
	logic               want_q, taken_q, last_q;
	logic [PW-1:0]      newest_q, pos_q;
	logic [CAW-1:0]     caddr_q;
	logic [TW-1:0]      cnt_q;
	logic [NW-1:0]      n_q;

	logic [6:0]        phases_e;
	logic [TW-1:0]     taps_e, np1, new_np1, nxt_newest_w, walk_cnt, push_cnt;
	logic signed [6:0] inc_raw;
	logic [5:0]        inc_e;
	logic [7:0]        p_sum, p_new;
	logic              wrap, done, in_acc;
	logic [PW-1:0]     nxt_newest;

	assign in_acc   = in_vld && in_rdy;
	assign phases_e = (int'(phase_count_q) > MAX_PHASES) ? 7'(MAX_PHASES)
	                                                      : {1'b0, phase_count_q};
	assign taps_e   = (tap_count_q == 6'd0) ? TW'(1)
	                : (int'(tap_count_q) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(tap_count_q);
	assign inc_raw  = $signed({2'b00, phase_step_q}) + 7'(step_trim_q);
	assign inc_e    = (inc_raw < 7'sd1) ? 6'd1 : inc_raw[5:0];
	assign p_sum    = {1'b0, phase_acc_q} + {2'b00, inc_e};
	assign wrap     = p_sum >= {1'b0, phases_e};
	assign p_new    = wrap ? p_sum - {1'b0, phases_e} : p_sum;
	assign done     = (int'(n_q) + 1 == CAP) || (wrap && taken_q);

	assign np1          = TW'(newest_q) + TW'(1);
	assign nxt_newest_w = (np1 < taps_e) ? np1 : '0;
	assign nxt_newest   = PW'(nxt_newest_w);
	assign walk_cnt     = (np1 > taps_e) ? np1 : taps_e;
	assign new_np1      = nxt_newest_w + TW'(1);
	assign push_cnt     = (new_np1 > taps_e) ? new_np1 : taps_e;

	always_comb begin
		cmd           = '0;
		cmd.sym_ld    = in_acc && (in_cmd == CMD_SYMBOL);
		cmd.coef_we   = in_acc && (in_cmd == CMD_COEF);
		cmd.map_we    = in_acc && (in_cmd == CMD_MAP);
		cmd.hist_clr  = in_acc && (in_cmd == CMD_RESTART);
		cmd.acc_clr   = (state_q == ST_CHECK);
		cmd.push      = (state_q == ST_PUSH);
		cmd.mac_issue = (state_q == ST_MAC);
		cmd.prod_ld   = (state_q == ST_DIFF);
	end

	assign in_rdy    = (state_q == ST_IDLE);
	assign out_vld   = (state_q == ST_SEND);
	assign out_last  = last_q;
	assign cfg_rdy   = 1'b1;
	assign push_pos  = nxt_newest;
	assign mac_pos   = pos_q;
	assign mac_caddr = caddr_q;
	assign map_en    = map_en_q;
	assign gain      = gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_count_q <= RST_PHASE_COUNT;
			phase_step_q  <= RST_PHASE_STEP;
			step_trim_q   <= RST_STEP_TRIM;
			map_en_q      <= RST_MAP_ENABLE;
			gain_q        <= RST_OUT_GAIN;
			tap_count_q   <= RST_TAP_COUNT;
			phase_acc_q   <= 7'(RST_PHASE_STEP);
			want_q        <= 1'b0;
			taken_q       <= 1'b0;
			last_q        <= 1'b0;
			newest_q      <= '0;
			pos_q         <= '0;
			caddr_q       <= '0;
			cnt_q         <= '0;
			n_q           <= '0;
		end else begin
			if (cfg_vld) begin
				unique case (cfg_idx)
					REG_PHASE_COUNT: phase_count_q <= cfg_dat[5:0];
					REG_PHASE_STEP:  phase_step_q  <= cfg_dat[4:0];
					REG_STEP_TRIM:   step_trim_q   <= cfg_dat[5:0];
					REG_MAP_ENABLE:  map_en_q      <= cfg_dat[0];
					REG_OUT_GAIN:    gain_q        <= cfg_dat;
					REG_TAP_COUNT:   tap_count_q   <= cfg_dat[5:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_cmd)
							CMD_RESTART: begin
								phase_acc_q <= {2'b00, phase_step_q};
								want_q      <= 1'b0;
								newest_q    <= '0;
							end
							CMD_SYMBOL: begin
								n_q     <= '0;
								taken_q <= 1'b0;
								state_q <= ST_CHECK;
							end
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					if (want_q) begin
						state_q <= ST_PUSH;
					end else begin
						pos_q   <= newest_q;
						caddr_q <= CAW'(phase_acc_q);
						cnt_q   <= walk_cnt;
						state_q <= ST_MAC;
					end
				end
				ST_PUSH: begin
					newest_q <= nxt_newest;
					taken_q  <= 1'b1;
					pos_q    <= nxt_newest;
					caddr_q  <= CAW'(phase_acc_q);
					cnt_q    <= push_cnt;
					state_q  <= ST_MAC;
				end
				ST_MAC: begin
					pos_q   <= (pos_q == '0) ? PW'(taps_e - TW'(1)) : pos_q - PW'(1);
					caddr_q <= CAW'(caddr_q + CAW'(phases_e));
					cnt_q   <= cnt_q - TW'(1);
					if (cnt_q == TW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.mac_busy) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					phase_acc_q <= p_new[6:0];
					want_q      <= wrap;
					n_q         <= n_q + NW'(1);
					last_q      <= done;
					state_q     <= ST_SEND;
				end
				ST_SEND: begin
					if (out_rdy) begin
						state_q <= last_q ? ST_IDLE : ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PPS_ASSERT_IMPL(a_in_out_excl, in_rdy, !out_vld)
	`PPS_ASSERT_IMPL(a_mac_cnt_live, state_q == ST_MAC, cnt_q != '0)
	`PPS_ASSERT_NEXT(a_last_to_idle, out_vld && out_rdy && last_q, state_q == ST_IDLE)
	`PPS_ASSERT_IMPL(a_newest_range, 1'b1, int'(newest_q) < MAX_TAPS)

endmodule

// File: src/polyphase_pulse_shaper.sv
// ----------------------------------------------------------------------------
// Polyphase pulse shaper
// Interpolating polyphase FIR transmit shaper with I/Q rails and output gain.
//
//   Channel  Direction  Signals                          Contents
//   s_*      in         tvalid tready tdata tuser         commands and symbols
//   m_*      out        tvalid tready tdata tlast         shaped samples
//   cfg_*    in         valid ready index data            register writes
//
// An output passes through a check state, a push state when it pushes a new
// symbol into the history, a MAC state that issues max(newest+1, taps) taps
// to the two rail MAC pipelines, one per cycle, a drain state, the gain stage
// and the send state. A symbol is busy until its last sample has been taken.
// Reset is asynchronous; no clearing pass is needed after reset.
// A stall on m_tready holds the sample and stops further work.
// ----------------------------------------------------------------------------
module polyphase_pulse_shaper
	import pps_pkg::*;
#(
	parameter int MAX_PHASES = DEF_MAX_PHASES,
	parameter int MAX_TAPS   = DEF_MAX_TAPS,
	parameter int COEF_DEPTH = DEF_COEF_DEPTH,
	parameter int MAP_DEPTH  = DEF_MAP_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sym_index, sym_i, sym_q, load_addr, load_value, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// cmd, load_rail
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sample
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CAW = $clog2(COEF_DEPTH);

	pps_cmd_t           cmd;
	pps_sts_t           sts;
	logic [PW-1:0]      push_pos, mac_pos;
	logic [CAW-1:0]     mac_caddr;
	logic               map_en;
	logic signed [15:0] gain;

	pps_ctrl #(
		.MAX_PHASES(MAX_PHASES),
		.MAX_TAPS(MAX_TAPS),
		.COEF_DEPTH(COEF_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(s_tvalid),
		.in_rdy(s_tready),
		.in_cmd(s_tuser[1:0]),
		.out_vld(m_tvalid),
		.out_rdy(m_tready),
		.out_last(m_tlast),
		.cfg_vld(cfg_valid),
		.cfg_rdy(cfg_ready),
		.cfg_idx(cfg_index),
		.cfg_dat(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.push_pos(push_pos),
		.mac_pos(mac_pos),
		.mac_caddr(mac_caddr),
		.map_en(map_en),
		.gain(gain)
	);

	pps_dp #(
		.MAX_TAPS(MAX_TAPS),
		.COEF_DEPTH(COEF_DEPTH),
		.MAP_DEPTH(MAP_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_data(s_tdata),
		.in_user(s_tuser),
		.push_pos(push_pos),
		.mac_pos(mac_pos),
		.mac_caddr(mac_caddr),
		.map_en(map_en),
		.gain(gain),
		.sample(m_tdata)
	);

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Polyphase pulse shaper testbench
// Loads a window of coefficient and constellation entries and then drives
// directed and random commands and symbols under register settings that keep
// every coefficient walk inside that window and every table index inside it
// or written first, with random idling on both streams. A predictor works out
// every shaped sample and its tlast, and the monitor compares each output
// transaction with the oldest outstanding sample.
// ----------------------------------------------------------------------------
module tb_top;
	import pps_pkg::*;

	localparam int  N_PHASES   = 32;
	localparam int  N_TAPS     = 32;
	localparam int  N_COEF     = 1024;
	localparam int  N_MAP      = 256;
	localparam int  COEF_WIN   = 32;
	localparam int  MAP_WIN    = 8;
	localparam int  SAMPLE_CAP = N_PHASES + 1;
	localparam int  SETTLE     = 200;
	localparam longint LIMIT   = 4000000;

	typedef struct {
		logic [15:0] sample;
		logic        last;
	} shaped_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	shaped_t         samples_due[$];
	int              mismatches;
	longint          cycle;
	longint          hold_end;
	int              src_idle_pct;
	int              snk_stall_pct;

	logic signed [15:0] hist_i[N_TAPS];
	logic signed [15:0] hist_q[N_TAPS];
	logic signed [15:0] coef_i[N_COEF];
	logic signed [15:0] coef_q[N_COEF];
	logic signed [15:0] map_i[N_MAP];
	logic signed [15:0] map_q[N_MAP];
	int unsigned        phase_acc;
	int unsigned        newest;
	bit                 want_sym;

	int unsigned        r_phase_count;
	int unsigned        r_phase_step;
	int unsigned        r_tap_count;
	int                 r_trim;
	bit                 r_map;
	logic signed [15:0] r_gain;

	polyphase_pulse_shaper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (cycle < hold_end) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		shaped_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (samples_due.size() == 0) begin
				report_mismatch("unexpected sample", m_tdata, 16'h0);
			end else begin
				e = samples_due.pop_front();
				if (m_tdata !== e.sample)
					report_mismatch("sample", m_tdata, e.sample);
				if (m_tlast !== e.last)
					report_mismatch("tlast", {15'd0, m_tlast}, {15'd0, e.last});
			end
		end
	end

	function automatic logic signed [15:0] rail_dot(input bit q_rail,
			input int unsigned phases, input int unsigned taps);
		logic [31:0]        acc;
		logic signed [31:0] prod;
		int unsigned        c;
		int                 k;
		acc = '0;
		c = phase_acc;
		for (k = int'(newest); k >= 0; k--) begin
			prod = q_rail ? hist_q[k % N_TAPS] * coef_q[c % N_COEF]
				: hist_i[k % N_TAPS] * coef_i[c % N_COEF];
			acc += prod;
			c += phases;
		end
		for (k = int'(taps) - 1; k > int'(newest); k--) begin
			prod = q_rail ? hist_q[k % N_TAPS] * coef_q[c % N_COEF]
				: hist_i[k % N_TAPS] * coef_i[c % N_COEF];
			acc += prod;
			c += phases;
		end
		return acc[30:15];
	endfunction

	function automatic void shape_symbol(input logic [7:0] idx,
			input logic signed [15:0] si, input logic signed [15:0] sq);
		int unsigned        taps;
		int unsigned        phases;
		int unsigned        p;
		int                 inc;
		int                 n;
		bit                 taken;
		logic signed [15:0] yi;
		logic signed [15:0] yq;
		logic signed [15:0] d;
		logic signed [31:0] prod;
		shaped_t            e;
		taps = (r_tap_count == 0) ? 1 : (r_tap_count > N_TAPS ? N_TAPS : r_tap_count);
		phases = (r_phase_count > N_PHASES) ? N_PHASES : r_phase_count;
		inc = int'(r_phase_step) + r_trim;
		if (inc < 1)
			inc = 1;
		taken = 0;
		n = 0;
		while (n < SAMPLE_CAP) begin
			if (want_sym) begin
				if (taken)
					break;
				taken = 1;
				newest = (newest + 1 < taps) ? newest + 1 : 0;
				newest = newest % N_TAPS;
				hist_i[newest] = r_map ? map_i[idx] : si;
				hist_q[newest] = r_map ? map_q[idx] : sq;
			end
			yi = rail_dot(0, phases, taps);
			yq = rail_dot(1, phases, taps);
			d = yi - yq;
			prod = d * r_gain;
			e.sample = prod[30:15];
			e.last = 1'b0;
			samples_due.push_back(e);
			n++;
			want_sym = 0;
			p = phase_acc + inc;
			if (p >= phases) begin
				p -= phases;
				want_sym = 1;
			end
			phase_acc = p & 127;
		end
		if (n > 0)
			samples_due[samples_due.size() - 1].last = 1'b1;
	endfunction

	function automatic void predict_item(input cmd_code_t cmd, input logic [7:0] idx,
			input logic [15:0] si, input logic [15:0] sq, input logic [9:0] addr,
			input logic [15:0] val, input logic rail_sel);
		int k;
		case (cmd)
			CMD_COEF: begin
				if (rail_sel) coef_q[addr] = val;
				else coef_i[addr] = val;
			end
			CMD_MAP: begin
				if (rail_sel) map_q[addr[7:0]] = val;
				else map_i[addr[7:0]] = val;
			end
			CMD_RESTART: begin
				for (k = 0; k < N_TAPS; k++) begin
					hist_i[k] = '0;
					hist_q[k] = '0;
				end
				phase_acc = r_phase_step & 127;
				want_sym = 0;
				newest = 0;
			end
			default: shape_symbol(idx, si, sq);
		endcase
	endfunction

	task automatic send_item(input cmd_code_t cmd, input logic [7:0] idx,
			input logic [15:0] si, input logic [15:0] sq, input logic [9:0] addr,
			input logic [15:0] val, input logic rail_sel);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, val, addr, sq, si, idx};
		s_tuser  <= {rail_sel, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(cmd, idx, si, sq, addr, val, rail_sel);
	endtask

	task automatic send_random_item();
		int        roll;
		cmd_code_t cmd;
		roll = $urandom_range(99);
		cmd = (roll < 80) ? CMD_SYMBOL : (roll < 88) ? CMD_COEF
			: (roll < 96) ? CMD_MAP : CMD_RESTART;
		send_item(cmd, 8'($urandom_range(MAP_WIN - 1)), 16'($urandom), 16'($urandom),
			10'($urandom_range(1023)), 16'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		stop_sending();
		while (samples_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PHASE_COUNT: r_phase_count = value[5:0];
			REG_PHASE_STEP:  r_phase_step = value[4:0];
			REG_STEP_TRIM:   r_trim = $signed(value[5:0]);
			REG_MAP_ENABLE:  r_map = value[0];
			REG_OUT_GAIN:    r_gain = value;
			REG_TAP_COUNT:   r_tap_count = value[5:0];
			default: ;
		endcase
	endtask

	// Every setting is followed by a restart so that the phase starts below
	// the phase count and the history is empty.
	task automatic write_all_regs(input int pc, input int ps, input int trim,
			input bit map_on, input int gain, input int taps);
		write_reg(REG_PHASE_COUNT, 16'(pc));
		write_reg(REG_PHASE_STEP, 16'(ps));
		write_reg(REG_STEP_TRIM, 16'(trim));
		write_reg(REG_MAP_ENABLE, {15'd0, map_on});
		write_reg(REG_OUT_GAIN, 16'(gain));
		write_reg(REG_TAP_COUNT, 16'(taps));
		@(posedge clk);
		send_item(CMD_RESTART, 8'd0, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
	endtask

	task automatic test_table_load();
		int a;
		int r;
		for (r = 0; r < 2; r++) begin
			for (a = 0; a < COEF_WIN; a++)
				send_item(CMD_COEF, 8'd0, 16'd0, 16'd0, 10'(a),
					($urandom_range(15) == 0) ? 16'h8000 : 16'($urandom), 1'(r));
			for (a = 0; a < MAP_WIN; a++)
				send_item(CMD_MAP, 8'd0, 16'd0, 16'd0, 10'(a),
					($urandom_range(15) == 0) ? 16'h7fff : 16'($urandom), 1'(r));
		end
		wait_drained();
	endtask

	task automatic test_directed();
		int i;
		// A trim that takes the step below one leaves the smallest advance.
		write_all_regs(1, 0, -31, 0, 16'h8000, 1);
		send_item(CMD_SYMBOL, 8'd0, 16'h7fff, 16'h8000, 10'd0, 16'd0, 1'b0);
		send_item(CMD_SYMBOL, 8'd0, 16'h8000, 16'h7fff, 10'd0, 16'd0, 1'b0);
		send_item(CMD_SYMBOL, 8'd0, 16'hffff, 16'h0001, 10'd0, 16'd0, 1'b0);
		wait_drained();
		// A tap count above the maximum is clamped, and the top map index is
		// written on both rails before it is used.
		write_all_regs(1, 0, 0, 1, 16'h4000, 50);
		send_item(CMD_MAP, 8'd0, 16'd0, 16'd0, 10'h3ff, 16'h8000, 1'b0);
		send_item(CMD_MAP, 8'd0, 16'd0, 16'd0, 10'h3ff, 16'h7fff, 1'b1);
		send_item(CMD_SYMBOL, 8'd3, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		send_item(CMD_SYMBOL, 8'd255, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		send_item(CMD_SYMBOL, 8'd7, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		wait_drained();
		// A phase count above the maximum is clamped.
		write_all_regs(45, 31, 1, 1, 16'h7fff, 1);
		send_item(CMD_SYMBOL, 8'd1, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		send_item(CMD_SYMBOL, 8'd2, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		wait_drained();
		// A smaller tap count leaves the newest position beyond it.
		write_all_regs(4, 1, 0, 1, 16'h7fff, 6);
		for (i = 0; i < 4; i++)
			send_item(CMD_SYMBOL, 8'(i), 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		wait_drained();
		write_reg(REG_TAP_COUNT, 16'd2);
		send_item(CMD_SYMBOL, 8'd5, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		send_item(CMD_SYMBOL, 8'd6, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		wait_drained();
		write_reg(REG_TAP_COUNT, 16'd0);
		send_item(CMD_SYMBOL, 8'd4, 16'd0, 16'd0, 10'd0, 16'd0, 1'b0);
		wait_drained();
	endtask

	task automatic test_random_phase(input int n_items, input int src_pct,
			input int snk_pct);
		int i;
		int pc;
		int ps;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		for (i = 0; i < n_items; i++) begin
			if (i % 20 == 0) begin
				wait_drained();
				pc = $urandom_range(5, 1);
				ps = $urandom_range(pc - 1);
				write_all_regs(pc, ps, int'($urandom_range(pc - ps + 2)) - 2,
					1'($urandom_range(1)), $urandom, $urandom_range(6, 1));
			end
			send_random_item();
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		int i;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		write_all_regs(4, 3, 0, 0, 16'h7fff, 6);
		hold_end = cycle + 600;
		for (i = 0; i < 12; i++)
			send_item(CMD_SYMBOL, 8'($urandom_range(MAP_WIN - 1)), 16'($urandom),
				16'($urandom), 10'd0, 16'd0, 1'b0);
		wait_drained();
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycle = 0;
		hold_end = 0;
		mismatches = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		for (k = 0; k < N_TAPS; k++) begin
			hist_i[k] = '0;
			hist_q[k] = '0;
		end
		phase_acc = RST_PHASE_STEP;
		newest = 0;
		want_sym = 0;
		r_phase_count = RST_PHASE_COUNT;
		r_phase_step = RST_PHASE_STEP;
		r_trim = $signed(RST_STEP_TRIM);
		r_map = RST_MAP_ENABLE;
		r_gain = RST_OUT_GAIN;
		r_tap_count = RST_TAP_COUNT;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_directed();
		test_random_phase(14, 0, 0);
		test_random_phase(14, 71, 0);
		test_random_phase(14, 0, 71);
		test_random_phase(14, 31, 31);
		test_backpressure();

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
